@@ rtl/rec_pkg.sv @@
// Shared types and constants for the rotary encoder counter.
package rec_pkg;

    localparam int VAL_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int MUL_STEPS = 16;

    localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_REV = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_SCALE = 2'd1;

    localparam logic [VAL_W-1:0] RST_COUNTS_PER_REV = 16'd24;
    localparam logic [VAL_W-1:0] RST_VELOCITY_SCALE = 16'd60;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } rec_state_t;

    typedef struct packed {
        logic start;
    } rec_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rec_stat_t;

endpackage

@@ rtl/rec_muldiv.sv @@
// Shared shift-add multiplier and restoring divider for the velocity read.
module rec_muldiv import rec_pkg::*; #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  rec_ctrl_t              ctrl,
    input  logic [COUNT_WIDTH-1:0] pulses,
    input  logic [VAL_W-1:0]       scale,
    input  logic [VAL_W-1:0]       divisor,
    output rec_stat_t              stat,
    output logic [VAL_W-1:0]       result
);

    localparam int PW     = COUNT_WIDTH + VAL_W;
    localparam int STEP_W = $clog2(PW);

    rec_state_t state_reg, state_next;

    logic [STEP_W-1:0]      cnt_reg;
    logic [PW-1:0]          acc_reg;
    logic [VAL_W:0]         rem_reg;
    logic [COUNT_WIDTH-1:0] mcand_reg;
    logic [VAL_W-1:0]       mplier_reg;
    logic [VAL_W-1:0]       divisor_reg;

    logic           mul_last;
    logic           div_last;
    logic [VAL_W:0] rem_sh;
    logic           rem_ge;
    logic [PW-1:0]  addend;

    assign mul_last = (cnt_reg == STEP_W'(MUL_STEPS - 1));
    assign div_last = (cnt_reg == STEP_W'(PW - 1));
    assign rem_sh   = {rem_reg[VAL_W-1:0], acc_reg[PW-1]};
    assign rem_ge   = (rem_sh >= {1'b0, divisor_reg});
    assign addend   = mplier_reg[VAL_W-1] ? PW'(mcand_reg) : '0;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (ctrl.start) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (mul_last) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        stat.busy = 1'b1;
        stat.done = 1'b0;
        case (state_reg)
            ST_IDLE: stat.busy = 1'b0;
            ST_DONE: stat.done = 1'b1;
            default: stat.busy = 1'b1;
        endcase
    end

    // quotient saturates to the result width
    assign result = (|acc_reg[PW-1:VAL_W]) ? '1 : acc_reg[VAL_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (ctrl.start) begin
                    mcand_reg   <= pulses;
                    mplier_reg  <= scale;
                    divisor_reg <= divisor;
                    acc_reg     <= '0;
                    cnt_reg     <= '0;
                end
            end
            ST_MUL: begin
                acc_reg    <= {acc_reg[PW-2:0], 1'b0} + addend;
                mplier_reg <= {mplier_reg[VAL_W-2:0], 1'b0};
                if (mul_last) begin
                    cnt_reg <= '0;
                    rem_reg <= '0;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            ST_DIV: begin
                rem_reg <= rem_ge ? (rem_sh - {1'b0, divisor_reg}) : rem_sh;
                acc_reg <= {acc_reg[PW-2:0], rem_ge};
                cnt_reg <= cnt_reg + 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

@@ rtl/rotary_encoder_counter_unit.sv @@
// Top level: rotary encoder pulse counter with velocity readout.
// Pin sample: result registered the next cycle; one per cycle unless busy or backpressured.
// Velocity read with pulses pending: 16 multiply steps, then COUNT_WIDTH + 16 divide steps and
//   a done state, all in one shared unit; not ready meanwhile.
// Velocity read with no pulses: handled like a sample, with velocity 0.
// Reset: counts_per_rev 24, velocity_scale 60, counters cleared, B held high.
module rotary_encoder_counter_unit import rec_pkg::*; #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VAL_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_req_type,
    input  logic                 s_pin_a,
    input  logic                 s_pin_b,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_direction,
    output logic [VAL_W-1:0]     m_position,
    output logic [VAL_W-1:0]     m_revolutions,
    output logic [VAL_W-1:0]     m_velocity,
    output logic                 m_edge_seen
);

    logic [VAL_W-1:0]       cpr_reg;
    logic [VAL_W-1:0]       vscale_reg;
    logic                   b_prev_reg;
    logic                   dir_reg, dir_next;
    logic [VAL_W-1:0]       pos_reg, pos_next;
    logic [VAL_W-1:0]       rev_reg, rev_next;
    logic [COUNT_WIDTH-1:0] pulse_reg, pulse_next;

    logic                   m_valid_reg;
    logic                   m_dir_reg;
    logic [VAL_W-1:0]       m_pos_reg;
    logic [VAL_W-1:0]       m_rev_reg;
    logic [VAL_W-1:0]       m_vel_reg;
    logic                   m_edge_reg;

    rec_ctrl_t        ctrl;
    rec_stat_t        stat;
    logic [VAL_W-1:0] unit_result;

    logic           s_acc;
    logic           is_read;
    logic           edge_hit;
    logic [VAL_W:0] pos_inc;
    logic           wrap;

    assign cfg_ready = 1'b1;
    assign s_ready   = !stat.busy && (!m_valid_reg || m_ready);
    assign s_acc     = s_valid && s_ready;
    assign is_read   = (s_req_type == REQ_READ);

    assign edge_hit = !is_read && s_pin_b && !b_prev_reg;
    assign pos_inc  = {1'b0, pos_reg} + 1'b1;
    assign wrap     = (pos_inc >= {1'b0, cpr_reg});

    assign ctrl.start = s_acc && is_read && (pulse_reg != '0);

    always_comb begin
        dir_next   = dir_reg;
        pos_next   = pos_reg;
        rev_next   = rev_reg;
        pulse_next = pulse_reg;
        if (s_acc) begin
            if (is_read) begin
                pulse_next = '0;
            end else if (edge_hit) begin
                dir_next = s_pin_a;
                pos_next = wrap ? '0 : pos_inc[VAL_W-1:0];
                rev_next = rev_reg + VAL_W'(wrap);
                if (pulse_reg != '1) begin
                    pulse_next = pulse_reg + 1'b1;
                end
            end
        end
    end

    rec_muldiv #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .pulses  (pulse_reg),
        .scale   (vscale_reg),
        .divisor (cpr_reg),
        .stat    (stat),
        .result  (unit_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cpr_reg    <= RST_COUNTS_PER_REV;
            vscale_reg <= RST_VELOCITY_SCALE;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_COUNTS_PER_REV: cpr_reg    <= cfg_data;
                REG_VELOCITY_SCALE: vscale_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_prev_reg <= 1'b1;
            dir_reg    <= 1'b0;
            pos_reg    <= '0;
            rev_reg    <= '0;
            pulse_reg  <= '0;
        end else begin
            if (s_acc && !is_read) begin
                b_prev_reg <= s_pin_b;
            end
            dir_reg   <= dir_next;
            pos_reg   <= pos_next;
            rev_reg   <= rev_next;
            pulse_reg <= pulse_next;
        end
    end

    // output register; a read that starts the unit completes on its done cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (stat.done || (s_acc && !ctrl.start)) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (stat.done) begin
            m_dir_reg  <= dir_reg;
            m_pos_reg  <= pos_reg;
            m_rev_reg  <= rev_reg;
            m_vel_reg  <= unit_result;
            m_edge_reg <= 1'b0;
        end else if (s_acc && !ctrl.start) begin
            m_dir_reg  <= dir_next;
            m_pos_reg  <= pos_next;
            m_rev_reg  <= rev_next;
            m_vel_reg  <= '0;
            m_edge_reg <= edge_hit;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_direction   = m_dir_reg;
    assign m_position    = m_pos_reg;
    assign m_revolutions = m_rev_reg;
    assign m_velocity    = m_vel_reg;
    assign m_edge_seen   = m_edge_reg;

    // the result slot is free by the time the divider finishes
    a_done_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.done |-> !m_valid_reg)
        else $error("divider finished while result slot occupied");

    // a read with pending pulses clears the count and occupies the unit
    a_read_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.start |=> (pulse_reg == '0) && stat.busy && !s_ready)
        else $error("velocity read did not clear pulse count or start unit");

    // a sample request produces its result on the next cycle
    a_sample_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && !is_read) |=> m_valid_reg)
        else $error("sample request produced no result");

    // position holds on a request without a B rising edge
    a_pos_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && !edge_hit) |=> $stable(pos_reg) && $stable(rev_reg))
        else $error("position changed without a B rising edge");

endmodule

@@ bench/rotary_encoder_counter_unit_tb.sv @@
// Testbench for the rotary encoder counter: mirrors the counters and checks every result in order.
`timescale 1ns / 1ps

module rotary_encoder_counter_unit_tb import rec_pkg::*; ();

    localparam int CNT_W        = 16;
    localparam int READ_LAT     = CNT_W + 33;
    localparam int WATCHDOG_MAX = 4000;
    localparam int RAND_ROUNDS  = 6;
    localparam int ROUND_ITEMS  = 112;

    typedef struct packed {
        logic             direction;
        logic [VAL_W-1:0] position;
        logic [VAL_W-1:0] revolutions;
        logic [VAL_W-1:0] velocity;
        logic             edge_seen;
    } enc_result_t;

    class encoder_mirror;
        logic [VAL_W-1:0] counts_per_rev, velocity_scale, rev_pos, rev_cnt;
        logic             b_last, dir_flag;
        longint unsigned  pulses, pulse_cap;
        enc_result_t      pending_results[$];
        int               errors;

        function new(longint unsigned cap);
            pulse_cap      = cap;
            counts_per_rev = RST_COUNTS_PER_REV;
            velocity_scale = RST_VELOCITY_SCALE;
            b_last         = 1'b1;
            dir_flag       = 1'b0;
            rev_pos        = '0;
            rev_cnt        = '0;
            pulses         = 0;
            errors         = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] val);
            if (idx == REG_COUNTS_PER_REV) begin
                counts_per_rev = val;
            end else if (idx == REG_VELOCITY_SCALE) begin
                velocity_scale = val;
            end
        endfunction

        function void note_request(logic req, logic a, logic b);
            enc_result_t     r;
            longint unsigned quot, scl, cpr;
            int unsigned     nxt;
            r   = '0;
            scl = velocity_scale;
            cpr = counts_per_rev;
            if (req == REQ_READ) begin
                if (pulses != 0) begin
                    if (cpr == 0) begin
                        quot = 64'hFFFF;
                    end else begin
                        quot = pulses * scl / cpr;
                    end
                    pulses     = 0;
                    r.velocity = (quot > 64'hFFFF) ? {VAL_W{1'b1}} : quot[VAL_W-1:0];
                end
            end else begin
                if (b && !b_last) begin
                    r.edge_seen = 1'b1;
                    dir_flag    = a;
                    if (pulses < pulse_cap) begin
                        pulses++;
                    end
                    nxt = rev_pos + 1;
                    if (nxt >= counts_per_rev) begin
                        nxt     = 0;
                        rev_cnt = rev_cnt + 1'b1;
                    end
                    rev_pos = nxt[VAL_W-1:0];
                end
                b_last = b;
            end
            r.direction   = dir_flag;
            r.position    = rev_pos;
            r.revolutions = rev_cnt;
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                errors++;
                $error("%s: expected %0d, actual %0d", name, want, got);
            end
        endfunction

        function void check_result(enc_result_t got);
            enc_result_t want;
            if (pending_results.size() == 0) begin
                errors++;
                $error("result with no request outstanding");
                return;
            end
            want = pending_results.pop_front();
            compare_field("direction", want.direction, got.direction);
            compare_field("position", want.position, got.position);
            compare_field("revolutions", want.revolutions, got.revolutions);
            compare_field("velocity", want.velocity, got.velocity);
            compare_field("edge_seen", want.edge_seen, got.edge_seen);
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [VAL_W-1:0]     cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_req_type;
    logic                 s_pin_a;
    logic                 s_pin_b;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_direction;
    logic [VAL_W-1:0]     m_position;
    logic [VAL_W-1:0]     m_revolutions;
    logic [VAL_W-1:0]     m_velocity;
    logic                 m_edge_seen;

    encoder_mirror mirror;
    bit            idle_on;
    int            quiet_cycles = 0;

    rotary_encoder_counter_unit #(
        .COUNT_WIDTH(CNT_W)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_pin_a      (s_pin_a),
        .s_pin_b      (s_pin_b),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_direction  (m_direction),
        .m_position   (m_position),
        .m_revolutions(m_revolutions),
        .m_velocity   (m_velocity),
        .m_edge_seen  (m_edge_seen)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        enc_result_t got;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                mirror.write_reg(cfg_index, cfg_data);
            end
            if (s_valid && s_ready) begin
                mirror.note_request(s_req_type, s_pin_a, s_pin_b);
            end
            if (m_valid && m_ready) begin
                got = '{m_direction, m_position, m_revolutions, m_velocity, m_edge_seen};
                mirror.check_result(got);
            end
            if ((cfg_valid && cfg_ready) || (s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else if (quiet_cycles >= WATCHDOG_MAX) begin
                $display("TB_ERROR");
                $finish;
            end else begin
                quiet_cycles = quiet_cycles + 1;
            end
        end
    end

    // result-side backpressure
    initial begin
        int hold;
        hold    = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (idle_on && hold == 0 && $urandom_range(0, 9) == 0) begin
                hold = $urandom_range(1, 10);
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_req(input logic req, input logic a, input logic b);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_pin_a    <= a;
        s_pin_b    <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic pulse(input logic a);
        send_req(REQ_SAMPLE, a, 1'b0);
        send_req(REQ_SAMPLE, a, 1'b1);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_regs(input logic [VAL_W-1:0] cpr, input logic [VAL_W-1:0] scale);
        cfg_write(REG_COUNTS_PER_REV, cpr);
        cfg_write(REG_VELOCITY_SCALE, scale);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (mirror.pending_results.size() != 0) @(negedge aclk);
        repeat (READ_LAT + 6) @(negedge aclk);
    endtask

    initial begin
        logic [1:0]       phase;
        logic             fwd;
        logic [VAL_W-1:0] cpr, scale;
        int               kind;

        mirror       = new((64'd1 << CNT_W) - 1);
        idle_on      = 1'b0;
        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        s_valid      = 1'b0;
        s_req_type   = REQ_SAMPLE;
        s_pin_a      = 1'b0;
        s_pin_b      = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_req(REQ_READ, 1'b0, 1'b0);
        send_req(REQ_SAMPLE, 1'b0, 1'b1);
        send_req(REQ_SAMPLE, 1'b1, 1'b0);
        send_req(REQ_SAMPLE, 1'b1, 1'b1);
        send_req(REQ_SAMPLE, 1'b1, 1'b1);
        send_req(REQ_SAMPLE, 1'b0, 1'b0);
        send_req(REQ_SAMPLE, 1'b0, 1'b1);
        send_req(REQ_READ, 1'b1, 1'b1);
        send_req(REQ_READ, 1'b0, 1'b0);
        send_req(REQ_SAMPLE, 1'b0, 1'b0);
        // read must not disturb the B history
        send_req(REQ_READ, 1'b1, 1'b1);
        send_req(REQ_SAMPLE, 1'b1, 1'b1);

        // zero counts per revolution
        wait_idle();
        set_regs('0, '1);
        pulse(1'b0);
        pulse(1'b1);
        send_req(REQ_READ, 1'b0, 1'b1);

        wait_idle();
        set_regs(16'd1, '1);
        pulse(1'b1);
        pulse(1'b0);
        send_req(REQ_READ, 1'b1, 1'b0);

        wait_idle();
        set_regs(16'd200, '0);
        repeat (4) pulse(1'b0);
        send_req(REQ_READ, 1'b0, 1'b0);

        // shrink the wrap point below the current position
        wait_idle();
        set_regs(16'd3, 16'd7);
        pulse(1'b1);
        send_req(REQ_READ, 1'b0, 1'b0);

        // pulse run at one count per revolution, then a read against a wide divisor
        wait_idle();
        set_regs(16'd1, 16'd1000);
        repeat (20) pulse(1'($urandom_range(0, 1)));
        wait_idle();
        set_regs('1, 16'd1000);
        send_req(REQ_READ, 1'b0, 1'b0);

        phase = 2'd0;
        fwd   = 1'b1;
        for (int r = 0; r < RAND_ROUNDS; r++) begin
            wait_idle();
            case (r)
                0: begin
                    cpr   = 16'd1;
                    scale = '0;
                end
                1: begin
                    cpr   = '1;
                    scale = '1;
                end
                default: begin
                    cpr   = ($urandom_range(0, 9) == 0) ? '0 : VAL_W'($urandom_range(1, 48));
                    scale = VAL_W'($urandom_range(0, 65535));
                end
            endcase
            set_regs(cpr, scale);
            for (int n = 0; n < ROUND_ITEMS; n++) begin
                if (n % 40 == 0) begin
                    idle_on = (r < RAND_ROUNDS - 1) && ($urandom_range(0, 3) != 0);
                end
                if (r == 2 && n == 60) begin
                    wait_idle();
                end
                kind = $urandom_range(0, 15);
                if (kind == 0) begin
                    send_req(REQ_READ, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end else if (kind == 1) begin
                    send_req(REQ_SAMPLE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end else begin
                    if ($urandom_range(0, 19) == 0) begin
                        fwd = !fwd;
                    end
                    if (kind != 2) begin
                        phase = fwd ? phase + 2'd1 : phase - 2'd1;
                    end
                    send_req(REQ_SAMPLE, phase[1], phase[1] ^ phase[0]);
                end
            end
        end

        idle_on = 1'b0;
        wait_idle();
        if (mirror.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
